// ===== sv/bvte_pkg.sv =====
// Shared types, opcodes and helpers for the binary value token encoder.
// No dependencies; every other file in sv/ refers to this package by scope.
package bvte_pkg;

  typedef enum logic [3:0] {
    OP_NULL     = 4'd0,
    OP_FALSE    = 4'd1,
    OP_TRUE     = 4'd2,
    OP_INT      = 4'd3,
    OP_FLOAT    = 4'd4,
    OP_DOUBLE   = 4'd5,
    OP_ARRLEN   = 4'd6,
    OP_ARRSTART = 4'd7,
    OP_ARREND   = 4'd8,
    OP_OBJLEN   = 4'd9,
    OP_OBJSTART = 4'd10,
    OP_OBJEND   = 4'd11,
    OP_STRHDR   = 4'd12,
    OP_BYTESHDR = 4'd13
  } op_t;

  // Fixed header bytes
  localparam logic [7:0] HDR_NULL     = 8'h00;
  localparam logic [7:0] HDR_FALSE    = 8'h02;
  localparam logic [7:0] HDR_TRUE     = 8'h03;
  localparam logic [7:0] HDR_END      = 8'h01;
  localparam logic [7:0] HDR_ARRSTART = 8'h2F;
  localparam logic [7:0] HDR_OBJSTART = 8'h3F;
  localparam logic [7:0] HDR_FLOAT    = 8'h05;
  localparam logic [7:0] HDR_DOUBLE   = 8'h06;
  localparam logic [7:0] HEAD_POSINT  = 8'h40;
  localparam logic [7:0] HEAD_NEGINT  = 8'h60;
  localparam logic [7:0] HEAD_ARR     = 8'h20;
  localparam logic [7:0] HEAD_OBJ     = 8'h30;
  localparam logic [7:0] HEAD_STR     = 8'hC0;
  localparam logic [7:0] HEAD_BYTES   = 8'h80;

  localparam logic [7:0] INT_BASE     = 8'd23;
  localparam logic [7:0] LIM_SHORT    = 8'd10;
  localparam logic [7:0] LIM_LONG     = 8'd59;

  localparam int QDEPTH = 2;

  // One classified token: header byte, payload word and payload byte count
  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] payload;
    logic [3:0]  nbytes;
  } desc_t;

  // Fewest bytes that hold v, at least one
  function automatic logic [3:0] byte_count(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (v[8*i +: 8] != 8'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/bvte_front.sv =====
// Front end: classify one token into header, payload and payload length.
// Depends on bvte_pkg.
module bvte_front (
  input  logic [3:0]       opcode,
  input  logic [63:0]      int_value,
  input  logic [63:0]      raw_value,
  output logic             known,
  output bvte_pkg::desc_t  desc
);

  logic        positive;
  logic        int_small;
  logic [63:0] int_excess;
  logic [3:0]  int_n;
  logic [7:0]  len_head;
  logic [7:0]  len_lim;
  logic        len_small;
  logic [63:0] len_diff;
  logic [63:0] len_excess;
  logic [3:0]  len_n;
  logic [4:0]  neg_mag;

  always_comb begin
    positive = !int_value[63] && (int_value != 64'd0);
    // negative excess is -v - 24 == ~v - 23
    int_excess = positive ? (int_value - 64'd25) : (~int_value - 64'd23);
    int_small  = positive ? (int_value <= 64'd24) : ($signed(int_value) >= -64'sd23);
    int_n      = bvte_pkg::byte_count(int_excess);
    neg_mag    = 5'd0 - int_value[4:0];

    case (opcode)
      bvte_pkg::OP_ARRLEN: begin
        len_head = bvte_pkg::HEAD_ARR;
        len_lim  = bvte_pkg::LIM_SHORT;
      end
      bvte_pkg::OP_OBJLEN: begin
        len_head = bvte_pkg::HEAD_OBJ;
        len_lim  = bvte_pkg::LIM_SHORT;
      end
      bvte_pkg::OP_STRHDR: begin
        len_head = bvte_pkg::HEAD_STR;
        len_lim  = bvte_pkg::LIM_LONG;
      end
      default: begin
        len_head = bvte_pkg::HEAD_BYTES;
        len_lim  = bvte_pkg::LIM_LONG;
      end
    endcase
    len_small  = raw_value <= {56'd0, len_lim};
    len_diff   = raw_value - {56'd0, len_lim};
    // header has room for four count bytes: saturate the excess
    len_excess = (len_diff[63:32] != 32'd0) ? 64'h0000_0000_FFFF_FFFF : len_diff;
    len_n      = bvte_pkg::byte_count(len_excess);

    known        = 1'b1;
    desc.head    = bvte_pkg::HDR_NULL;
    desc.payload = 64'd0;
    desc.nbytes  = 4'd0;
    case (opcode)
      bvte_pkg::OP_NULL:     desc.head = bvte_pkg::HDR_NULL;
      bvte_pkg::OP_FALSE:    desc.head = bvte_pkg::HDR_FALSE;
      bvte_pkg::OP_TRUE:     desc.head = bvte_pkg::HDR_TRUE;
      bvte_pkg::OP_ARRSTART: desc.head = bvte_pkg::HDR_ARRSTART;
      bvte_pkg::OP_OBJSTART: desc.head = bvte_pkg::HDR_OBJSTART;
      bvte_pkg::OP_ARREND,
      bvte_pkg::OP_OBJEND:   desc.head = bvte_pkg::HDR_END;
      bvte_pkg::OP_FLOAT: begin
        desc.head    = bvte_pkg::HDR_FLOAT;
        desc.payload = {32'd0, raw_value[31:0]};
        desc.nbytes  = 4'd4;
      end
      bvte_pkg::OP_DOUBLE: begin
        desc.head    = bvte_pkg::HDR_DOUBLE;
        desc.payload = raw_value;
        desc.nbytes  = 4'd8;
      end
      bvte_pkg::OP_INT: begin
        if (int_small) begin
          desc.head = positive
                    ? (bvte_pkg::HEAD_POSINT | {3'd0, int_value[4:0] - 5'd1})
                    : (bvte_pkg::HEAD_NEGINT | {3'd0, neg_mag});
        end else begin
          desc.head    = (positive ? bvte_pkg::HEAD_POSINT : bvte_pkg::HEAD_NEGINT)
                       | (bvte_pkg::INT_BASE + {4'd0, int_n});
          desc.payload = int_excess;
          desc.nbytes  = int_n;
        end
      end
      bvte_pkg::OP_ARRLEN,
      bvte_pkg::OP_OBJLEN,
      bvte_pkg::OP_STRHDR,
      bvte_pkg::OP_BYTESHDR: begin
        if (len_small) begin
          desc.head = len_head | raw_value[7:0];
        end else begin
          desc.head    = len_head | (len_lim + {4'd0, len_n});
          desc.payload = len_excess;
          desc.nbytes  = len_n;
        end
      end
      default: known = 1'b0;
    endcase
  end

endmodule

// ===== sv/bvte_queue.sv =====
// Two-entry descriptor queue between the front and back ends.
// Depends on bvte_pkg.
module bvte_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bvte_pkg::desc_t  push_desc,
  input  logic             pop,
  output bvte_pkg::desc_t  head_desc,
  output logic             not_empty,
  output logic             full
);

  bvte_pkg::desc_t entries [bvte_pkg::QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign full      = count == 2'(bvte_pkg::QDEPTH);
  assign head_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/bvte_back.sv =====
// Back end: serialize one descriptor as header byte then payload bytes.
// Depends on bvte_pkg.
module bvte_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  bvte_pkg::desc_t  q_desc,
  output logic             q_pop,
  output logic             strobe,
  output logic [7:0]       out_byte,
  output logic             last_byte
);

  logic [71:0] shreg;
  logic [3:0]  remain;

  // take the next descriptor when the current one is done or on its last byte
  assign q_pop = q_not_empty && (remain <= 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 4'd0;
      strobe <= 1'b0;
    end else begin
      strobe <= remain != 4'd0;
      if (q_pop) begin
        remain <= q_desc.nbytes + 4'd1;
      end else if (remain != 4'd0) begin
        remain <= remain - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte  <= shreg[7:0];
    last_byte <= remain == 4'd1;
    if (q_pop) begin
      shreg <= {q_desc.payload, q_desc.head};
    end else begin
      shreg <= {8'd0, shreg[71:8]};
    end
  end

endmodule

// ===== sv/binary_value_token_encoder.sv =====
// Top level of the binary value token encoder.
// Depends on bvte_pkg, bvte_front, bvte_queue and bvte_back.
//
// Usage:
//   Input channel: drive opcode, int_value and raw_value and raise start;
//   the token is taken at a rising edge where start is high and busy is low.
//   Output channel: each encoded byte appears on out_byte for one cycle with
//   strobe high; last_byte marks the final beat of a token. The receiver
//   must take every beat; there is no back pressure on the output.
// Path: when the back end is idle, the first beat of a token passes from the
//   queue entry through the back end's shift register to its output register.
// Throughput: one output beat per cycle while tokens are queued; a token is
//   1 + payload-byte-count beats (1 to 9). The serializer in the back end sets
//   this rate; the two-entry queue lets the front accept tokens while it drains.
// Tokens with opcodes 14 and 15 are accepted and dropped with no output.
// Reset (synchronous, active high) empties the queue and the serializer;
// busy is low right after reset.
module binary_value_token_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  opcode,
  input  logic [63:0] int_value,
  input  logic [63:0] raw_value,
  output logic        strobe,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  bvte_pkg::desc_t front_desc;
  bvte_pkg::desc_t q_desc;
  logic            known;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  logic            push;

  // hold off new tokens while the queue is full
  assign busy = q_full;
  // drop undefined opcodes at the front: accepted, never queued
  assign push = start && !q_full && known;

  bvte_front u_front (
    .opcode    (opcode),
    .int_value (int_value),
    .raw_value (raw_value),
    .known     (known),
    .desc      (front_desc)
  );

  bvte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (front_desc),
    .pop       (q_pop),
    .head_desc (q_desc),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  bvte_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_desc      (q_desc),
    .q_pop       (q_pop),
    .strobe      (strobe),
    .out_byte    (out_byte),
    .last_byte   (last_byte)
  );

endmodule

// ===== dv/tb_binary_value_token_encoder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binary_value_token_encoder.
// Depends on bvte_pkg (opcodes, header constants) and the RTL top in sv/.
module tb_binary_value_token_encoder;

  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  // One output beat as the encoder should produce it
  typedef struct {
    logic [7:0] value;
    logic       last;
  } encoded_beat_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic [3:0]  opcode    = 4'd0;
  logic [63:0] int_value = 64'd0;
  logic [63:0] raw_value = 64'd0;
  logic        busy;
  logic        strobe;
  logic [7:0]  out_byte;
  logic        last_byte;

  // Bytes still owed by the encoder, oldest first
  encoded_beat_t pending_bytes[$];
  // Scratch buffer for the token being encoded
  logic [7:0]    token_bytes[$];

  int max_gap          = 4;
  int tokens_accepted  = 0;
  int ignored_accepted = 0;
  int beats_checked    = 0;
  int mismatches       = 0;
  int idle_cycles      = 0;

  binary_value_token_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .int_value (int_value),
    .raw_value (raw_value),
    .strobe    (strobe),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Encoding predictor
  // ---------------------------------------------------------------------------

  // Fewest little-endian bytes that hold v, never less than one
  function automatic int min_bytes(input logic [63:0] v);
    int n = 1;
    while (n < 8 && (v >> (8 * n)) != 64'd0) n++;
    return n;
  endfunction

  function automatic void append_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) token_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Header carries base + byte count, then the excess follows little-endian
  function automatic void append_header_excess(input logic [7:0] head,
                                               input logic [7:0] base,
                                               input logic [63:0] excess);
    int n = min_bytes(excess);
    token_bytes.push_back(head | (base + 8'(n)));
    append_le(excess, n);
  endfunction

  function automatic void append_length(input logic [7:0] head, input logic [7:0] limit,
                                        input logic [63:0] len);
    logic [63:0] excess;
    if (len <= 64'(limit)) begin
      token_bytes.push_back(head | len[7:0]);
    end else begin
      excess = len - 64'(limit);
      // Only four count bytes fit in the header: clamp the excess
      if (excess > 64'hFFFF_FFFF) excess = 64'hFFFF_FFFF;
      append_header_excess(head, limit, excess);
    end
  endfunction

  function automatic void append_int(input logic [63:0] bits);
    logic [63:0] mag;
    if (!bits[63] && bits != 64'd0) begin
      // Positive: 1..24 sit inline as v - 1, larger ones carry v - 25
      if (bits <= 64'd24) begin
        token_bytes.push_back(bvte_pkg::HEAD_POSINT | 8'(bits - 64'd1));
      end else begin
        append_header_excess(bvte_pkg::HEAD_POSINT, bvte_pkg::INT_BASE, bits - 64'd25);
      end
    end else begin
      // Zero and negatives: magnitude 0..23 inline, larger ones carry m - 24.
      // The most negative value wraps to 2^63 here, taken as unsigned.
      mag = 64'd0 - bits;
      if (mag <= 64'd23) begin
        token_bytes.push_back(bvte_pkg::HEAD_NEGINT | mag[7:0]);
      end else begin
        append_header_excess(bvte_pkg::HEAD_NEGINT, bvte_pkg::INT_BASE, mag - 64'd24);
      end
    end
  endfunction

  // Queue every byte one token should produce, flagging the final one
  function automatic void encode_token(input logic [3:0] op, input logic [63:0] iv,
                                       input logic [63:0] rv);
    token_bytes.delete();
    case (op)
      bvte_pkg::OP_NULL:     token_bytes.push_back(bvte_pkg::HDR_NULL);
      bvte_pkg::OP_FALSE:    token_bytes.push_back(bvte_pkg::HDR_FALSE);
      bvte_pkg::OP_TRUE:     token_bytes.push_back(bvte_pkg::HDR_TRUE);
      bvte_pkg::OP_INT:      append_int(iv);
      bvte_pkg::OP_FLOAT: begin
        token_bytes.push_back(bvte_pkg::HDR_FLOAT);
        append_le({32'd0, rv[31:0]}, 4);
      end
      bvte_pkg::OP_DOUBLE: begin
        token_bytes.push_back(bvte_pkg::HDR_DOUBLE);
        append_le(rv, 8);
      end
      bvte_pkg::OP_ARRLEN:   append_length(bvte_pkg::HEAD_ARR, bvte_pkg::LIM_SHORT, rv);
      bvte_pkg::OP_ARRSTART: token_bytes.push_back(bvte_pkg::HDR_ARRSTART);
      bvte_pkg::OP_ARREND:   token_bytes.push_back(bvte_pkg::HDR_END);
      bvte_pkg::OP_OBJLEN:   append_length(bvte_pkg::HEAD_OBJ, bvte_pkg::LIM_SHORT, rv);
      bvte_pkg::OP_OBJSTART: token_bytes.push_back(bvte_pkg::HDR_OBJSTART);
      bvte_pkg::OP_OBJEND:   token_bytes.push_back(bvte_pkg::HDR_END);
      bvte_pkg::OP_STRHDR:   append_length(bvte_pkg::HEAD_STR, bvte_pkg::LIM_LONG, rv);
      bvte_pkg::OP_BYTESHDR: append_length(bvte_pkg::HEAD_BYTES, bvte_pkg::LIM_LONG, rv);
      default:     ; // undefined opcodes are swallowed without output
    endcase
    foreach (token_bytes[i]) begin
      pending_bytes.push_back('{token_bytes[i], i == token_bytes.size() - 1});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check output beats, predict accepted tokens, watch for hangs.
  // Everything is sampled at the rising edge, before that edge's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    encoded_beat_t want;
    if (!rst) begin
      // Check before predicting so a token accepted on this edge is never
      // matched against a beat that was already on the wire.
      if (strobe) begin
        if (pending_bytes.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected beat: byte %02h last %0b", out_byte, last_byte);
          end
          mismatches++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.value || last_byte !== want.last) begin
            if (mismatches < MAX_REPORTS) begin
              $display("beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       beats_checked, want.value, want.last, out_byte, last_byte);
            end
            mismatches++;
          end
          beats_checked++;
        end
      end
      if (start && !busy) begin
        encode_token(opcode, int_value, raw_value);
        tokens_accepted++;
        if (opcode > bvte_pkg::OP_BYTESHDR) ignored_accepted++;
      end
      // Reset the hang counter on any traffic in either direction
      if (strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one token and return on the edge that accepts it. Start stays high
  // on return so back-to-back tokens keep it asserted without a dip.
  task automatic send_token(input logic [3:0] op, input logic [63:0] iv,
                            input logic [63:0] rv);
    int gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    int_value <= iv;
    raw_value <= rv;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every owed beat has come out
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Mix of small values, byte-count boundaries around base, and wide values
  function automatic logic [63:0] random_value(input logic [63:0] base);
    case ($urandom_range(0, 3))
      0:       return 64'($urandom_range(0, 70));
      1:       return base + (64'd1 << (8 * $urandom_range(0, 7))) - 64'd1
                      + 64'($urandom_range(0, 2));
      2:       return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_literals();
    send_token(bvte_pkg::OP_NULL,     64'd0, 64'd0);
    send_token(bvte_pkg::OP_FALSE,    64'd0, 64'd0);
    send_token(bvte_pkg::OP_TRUE,     64'd0, 64'd0);
    send_token(bvte_pkg::OP_ARRSTART, 64'd0, 64'd0);
    send_token(bvte_pkg::OP_ARREND,   64'd0, 64'd0);
    send_token(bvte_pkg::OP_OBJSTART, 64'd0, 64'd0);
    send_token(bvte_pkg::OP_OBJEND,   64'd0, 64'd0);
  endtask

  task automatic test_int_extremes();
    send_token(bvte_pkg::OP_INT, 64'd1,  64'd0);
    send_token(bvte_pkg::OP_INT, 64'd24, 64'd0);     // top of the inline range
    send_token(bvte_pkg::OP_INT, 64'd25, 64'd0);     // first one with a payload
    send_token(bvte_pkg::OP_INT, 64'd0,  64'd0);
    send_token(bvte_pkg::OP_INT, -64'sd23, 64'd0);
    send_token(bvte_pkg::OP_INT, -64'sd24, 64'd0);
    send_token(bvte_pkg::OP_INT, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    send_token(bvte_pkg::OP_INT, 64'h8000_0000_0000_0000, 64'd0); // magnitude wraps
  endtask

  task automatic test_float_double();
    // Upper half of raw_value must not leak into the float payload
    send_token(bvte_pkg::OP_FLOAT,  64'd0, 64'hFFFF_FFFF_3F80_0000);
    send_token(bvte_pkg::OP_DOUBLE, 64'd0, 64'h8000_0000_0000_0001);
  endtask

  task automatic test_lengths();
    send_token(bvte_pkg::OP_ARRLEN,   64'd0, 64'd10);  // inline limit
    send_token(bvte_pkg::OP_OBJLEN,   64'd0, 64'd11);  // one past the limit
    send_token(bvte_pkg::OP_STRHDR,   64'd0, 64'd59);
    send_token(bvte_pkg::OP_BYTESHDR, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF); // excess saturates
  endtask

  task automatic test_ignored_opcodes();
    send_token(4'd14, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_token(4'd15, 64'd0, 64'd0);
  endtask

  // Burst of the longest tokens back to back, then stop until the queue empties
  task automatic test_drain_pause();
    int saved_gap = max_gap;
    max_gap = 0;
    repeat (6) send_token(bvte_pkg::OP_DOUBLE, {$urandom, $urandom}, {$urandom, $urandom});
    wait_for_drain();
    send_token(bvte_pkg::OP_NULL, 64'd0, 64'd0);
    max_gap = saved_gap;
  endtask

  task automatic test_random_tokens(input int count);
    int          sent = 0;
    logic [3:0]  op;
    logic [63:0] iv;
    logic [63:0] rv;
    while (sent < count) begin
      // Alternate stretches of random gaps with stretches of full rate
      if (sent % 50 == 0) max_gap = (max_gap == 0) ? 4 : 0;
      if (sent % 120 == 119) wait_for_drain();
      op = ($urandom_range(0, 31) == 0) ? 4'($urandom_range(14, 15))
                                        : 4'($urandom_range(0, 13));
      iv = random_value(64'd24);
      if ($urandom_range(0, 1)) iv = -iv;
      rv = random_value(($urandom_range(0, 1)) ? 64'(bvte_pkg::LIM_SHORT)
                                               : 64'(bvte_pkg::LIM_LONG));
      send_token(op, iv, rv);
      // Swallowed opcodes do not advance the count
      if (op <= bvte_pkg::OP_BYTESHDR) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_literals();
    test_int_extremes();
    test_float_double();
    test_lengths();
    test_ignored_opcodes();
    test_drain_pause();
    test_random_tokens(400);

    // Drain the tail and give the serializer time to show any stray beats
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d tokens (%0d with undefined opcodes) over all opcodes,",
             tokens_accepted, ignored_accepted);
    $display("inline, multi-byte and saturated encodings; %0d output beats compared.",
             beats_checked);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
